// ----- hdl/pts_pkg.sv -----
// Shared types and constants for the priority task scheduler.
package pts_pkg;

  typedef enum logic [2:0] {
    MODE_CREATE    = 3'd0,
    MODE_DELAY     = 3'd1,
    MODE_TICK      = 3'd2,
    MODE_START     = 3'd3,
    MODE_ISR_ENTER = 3'd4,
    MODE_ISR_EXIT  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_DELAYED = 2'd2
  } slot_status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_C_POP,
    ST_C_PREV,
    ST_INS_WALK,
    ST_INS_LINK1,
    ST_INS_LINK2,
    ST_INS_LINK3,
    ST_D_FIRST,
    ST_D_PREV,
    ST_D_HEAD,
    ST_D_WALK,
    ST_D_LINK1,
    ST_D_LINK2,
    ST_T_WALK,
    ST_T_UNLINK1,
    ST_T_UNLINK2,
    ST_T_CONT,
    ST_SCHED,
    ST_DONE
  } state_e;

  localparam logic [7:0] IDLE_PRIORITY = 8'd100;
  localparam logic [7:0] ISR_DEPTH_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  priority_req;
    logic [15:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic        running_valid;
    logic [3:0]  running_task;
    logic        switched;
    logic [3:0]  new_task;
    logic        error;
    logic [15:0] switch_count;
    logic [15:0] tick_count;
  } out_item_t;

endpackage

// ----- hdl/priority_task_scheduler_with_delays.sv -----
// Top level: task scheduler with ready, delayed and free slot lists.
//
// Usage: one event beat on the input channel (valid/stall), one status
// beat on the output channel. Modes: create, delay head ready task, tick,
// start, ISR enter, ISR exit. The block takes one event at a time; in_stall_o
// stays high while the event is worked through.
// Sequencing: a sequencer walks the slot table one entry per cycle through a
// single table read port and a single write port. A tick walks the delayed
// list and stops the walk for a ready-list insertion of each expiring task.
// The result sits in an output register; the next event is accepted while
// it waits. If the receiver stalls, the sequencer holds its finished result
// in the last step until the output register frees up.
// Reset: slot 0 holds the idle task (priority 100, ready), the other slots
// are free, counters clear and no task runs until a start event.
module priority_task_scheduler_with_delays #(
  parameter int MAX_TASKS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pts_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pts_pkg::out_item_t out_data_o
);

  localparam int NSLOTS = MAX_TASKS + 1;
  localparam int W      = $clog2(NSLOTS + 1);
  localparam int IW     = $clog2(NSLOTS);
  localparam logic [W-1:0] NONE = W'(NSLOTS);

  function automatic logic vld(input logic [W-1:0] s);
    return s < NONE;
  endfunction

  // slot table
  logic [1:0]   status_q [NSLOTS];
  logic [7:0]   prio_q   [NSLOTS];
  logic [15:0]  rem_q    [NSLOTS];
  logic [W-1:0] next_q   [NSLOTS];
  logic [W-1:0] prev_q   [NSLOTS];

  pts_pkg::state_e state_q, state_d;
  pts_pkg::in_item_t req_q, req_d;
  logic [W-1:0] ready_head_q, ready_head_d;
  logic [W-1:0] delayed_head_q, delayed_head_d;
  logic [W-1:0] free_head_q, free_head_d;
  logic [W-1:0] cur_q, cur_d;
  logic         started_q, started_d;
  logic [7:0]   nest_q, nest_d;
  logic [15:0]  sw_cnt_q, sw_cnt_d;
  logic [15:0]  ticks_q, ticks_d;
  logic [W-1:0] slot_q, slot_d;
  logic [W-1:0] p_q, p_d;
  logic [W-1:0] last_q, last_d;
  logic [W-1:0] nx_q, nx_d;
  logic [W-1:0] pv_q, pv_d;
  logic [W-1:0] n_q, n_d;
  logic [W-1:0] tn_q, tn_d;
  logic [7:0]   ins_prio_q, ins_prio_d;
  logic         ret_tick_q, ret_tick_d;
  logic         sw_q, sw_d;
  logic         err_q, err_d;
  logic [W-1:0] created_q, created_d;
  logic         out_valid_q, out_valid_d;
  pts_pkg::out_item_t out_data_q;
  logic         out_load;

  logic [W-1:0] rd_addr, wr_addr;
  logic [7:0]   rd_prio;
  logic [15:0]  rd_rem;
  logic [W-1:0] rd_next, rd_prev;
  logic         we_status, we_prio, we_rem, we_next, we_prev;
  logic [1:0]   wd_status;
  logic [7:0]   wd_prio;
  logic [15:0]  wd_rem;
  logic [W-1:0] wd_next, wd_prev;

  assign rd_prio   = prio_q[rd_addr[IW-1:0]];
  assign rd_rem    = rem_q[rd_addr[IW-1:0]];
  assign rd_next   = next_q[rd_addr[IW-1:0]];
  assign rd_prev   = prev_q[rd_addr[IW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOTS; i++) begin
        status_q[i] <= (i == 0) ? pts_pkg::SLOT_READY : pts_pkg::SLOT_FREE;
        prio_q[i]   <= (i == 0) ? pts_pkg::IDLE_PRIORITY : 8'd0;
        rem_q[i]    <= 16'd0;
        next_q[i]   <= (i >= 1 && i + 1 < NSLOTS) ? W'(i + 1) : NONE;
        prev_q[i]   <= NONE;
      end
    end else begin
      if (we_status) status_q[wr_addr[IW-1:0]] <= wd_status;
      if (we_prio)   prio_q[wr_addr[IW-1:0]]   <= wd_prio;
      if (we_rem)    rem_q[wr_addr[IW-1:0]]    <= wd_rem;
      if (we_next)   next_q[wr_addr[IW-1:0]]   <= wd_next;
      if (we_prev)   prev_q[wr_addr[IW-1:0]]   <= wd_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pts_pkg::ST_IDLE;
      ready_head_q   <= '0;
      delayed_head_q <= NONE;
      free_head_q    <= (NSLOTS > 1) ? W'(1) : NONE;
      cur_q          <= NONE;
      started_q      <= 1'b0;
      nest_q         <= 8'd0;
      sw_cnt_q       <= 16'd0;
      ticks_q        <= 16'd0;
      out_valid_q    <= 1'b0;
      ret_tick_q     <= 1'b0;
    end else begin
      state_q        <= state_d;
      ready_head_q   <= ready_head_d;
      delayed_head_q <= delayed_head_d;
      free_head_q    <= free_head_d;
      cur_q          <= cur_d;
      started_q      <= started_d;
      nest_q         <= nest_d;
      sw_cnt_q       <= sw_cnt_d;
      ticks_q        <= ticks_d;
      out_valid_q    <= out_valid_d;
      ret_tick_q     <= ret_tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    slot_q     <= slot_d;
    p_q        <= p_d;
    last_q     <= last_d;
    nx_q       <= nx_d;
    pv_q       <= pv_d;
    n_q        <= n_d;
    tn_q       <= tn_d;
    ins_prio_q <= ins_prio_d;
    sw_q       <= sw_d;
    err_q      <= err_d;
    created_q  <= created_d;
    if (out_load) begin
      out_data_q.running_valid <= vld(cur_q);
      out_data_q.running_task  <= vld(cur_q) ? 4'(cur_q) : 4'd0;
      out_data_q.switched      <= sw_q;
      out_data_q.new_task      <= 4'(created_q);
      out_data_q.error         <= err_q;
      out_data_q.switch_count  <= sw_cnt_q;
      out_data_q.tick_count    <= ticks_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    req_d          = req_q;
    ready_head_d   = ready_head_q;
    delayed_head_d = delayed_head_q;
    free_head_d    = free_head_q;
    cur_d          = cur_q;
    started_d      = started_q;
    nest_d         = nest_q;
    sw_cnt_d       = sw_cnt_q;
    ticks_d        = ticks_q;
    slot_d         = slot_q;
    p_d            = p_q;
    last_d         = last_q;
    nx_d           = nx_q;
    pv_d           = pv_q;
    n_d            = n_q;
    tn_d           = tn_q;
    ins_prio_d     = ins_prio_q;
    ret_tick_d     = ret_tick_q;
    sw_d           = sw_q;
    err_d          = err_q;
    created_d      = created_q;
    out_load       = 1'b0;
    rd_addr        = p_q;
    wr_addr        = slot_q;
    we_status      = 1'b0;
    we_prio        = 1'b0;
    we_rem         = 1'b0;
    we_next        = 1'b0;
    we_prev        = 1'b0;
    wd_status      = pts_pkg::SLOT_READY;
    wd_prio        = req_q.priority_req;
    wd_rem         = 16'd0;
    wd_next        = NONE;
    wd_prev        = NONE;

    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_data_i;
          sw_d      = 1'b0;
          err_d     = 1'b0;
          created_d = '0;
          state_d   = pts_pkg::ST_DONE;
          case (in_data_i.mode)
            pts_pkg::MODE_CREATE: begin
              if (!vld(free_head_q)) begin
                err_d = 1'b1;
              end else begin
                slot_d  = free_head_q;
                state_d = pts_pkg::ST_C_POP;
              end
            end
            pts_pkg::MODE_DELAY: begin
              if (in_data_i.delay_ticks != 16'd0 && vld(ready_head_q)) begin
                slot_d  = ready_head_q;
                state_d = pts_pkg::ST_D_FIRST;
              end
            end
            pts_pkg::MODE_TICK: begin
              ticks_d = ticks_q + 16'd1;
              p_d     = delayed_head_q;
              tn_d    = '0;
              state_d = pts_pkg::ST_T_WALK;
            end
            pts_pkg::MODE_START: begin
              started_d = 1'b1;
              state_d   = pts_pkg::ST_SCHED;
            end
            pts_pkg::MODE_ISR_ENTER: begin
              if (nest_q != pts_pkg::ISR_DEPTH_MAX) nest_d = nest_q + 8'd1;
            end
            pts_pkg::MODE_ISR_EXIT: begin
              if (nest_q != 8'd0) begin
                nest_d = nest_q - 8'd1;
                if (nest_q == 8'd1) state_d = pts_pkg::ST_SCHED;
              end
            end
            default: ;
          endcase
        end
      end
      pts_pkg::ST_C_POP: begin
        rd_addr     = slot_q;
        free_head_d = rd_next;
        we_prio     = 1'b1;
        we_rem      = 1'b1;
        ins_prio_d  = req_q.priority_req;
        created_d   = slot_q;
        state_d     = pts_pkg::ST_C_PREV;
      end
      pts_pkg::ST_C_PREV: begin
        if (vld(free_head_q)) begin
          wr_addr = free_head_q;
          we_prev = 1'b1;
        end
        p_d        = ready_head_q;
        last_d     = NONE;
        n_d        = '0;
        ret_tick_d = 1'b0;
        state_d    = pts_pkg::ST_INS_WALK;
      end
      pts_pkg::ST_INS_WALK: begin
        // stop at the first task strictly less urgent than the new one
        if (vld(p_q) && n_q < NONE && !(ins_prio_q < rd_prio)) begin
          last_d = p_q;
          p_d    = rd_next;
          n_d    = n_q + W'(1);
        end else begin
          state_d = pts_pkg::ST_INS_LINK1;
        end
      end
      pts_pkg::ST_INS_LINK1: begin
        we_prev   = 1'b1;
        wd_prev   = last_q;
        we_next   = 1'b1;
        wd_next   = p_q;
        we_status = 1'b1;
        wd_status = pts_pkg::SLOT_READY;
        state_d   = pts_pkg::ST_INS_LINK2;
      end
      pts_pkg::ST_INS_LINK2: begin
        if (vld(last_q)) begin
          wr_addr = last_q;
          we_next = 1'b1;
          wd_next = slot_q;
        end else begin
          ready_head_d = slot_q;
        end
        state_d = pts_pkg::ST_INS_LINK3;
      end
      pts_pkg::ST_INS_LINK3: begin
        if (vld(p_q)) begin
          wr_addr = p_q;
          we_prev = 1'b1;
          wd_prev = slot_q;
        end
        state_d = ret_tick_q ? pts_pkg::ST_T_CONT : pts_pkg::ST_SCHED;
      end
      pts_pkg::ST_D_FIRST: begin
        rd_addr = slot_q;
        if (!vld(rd_next)) begin
          err_d   = 1'b1;
          state_d = pts_pkg::ST_DONE;
        end else begin
          ready_head_d = rd_next;
          nx_d         = rd_next;
          we_rem       = 1'b1;
          wd_rem       = req_q.delay_ticks;
          we_status    = 1'b1;
          wd_status    = pts_pkg::SLOT_DELAYED;
          we_next      = 1'b1;
          state_d      = pts_pkg::ST_D_PREV;
        end
      end
      pts_pkg::ST_D_PREV: begin
        wr_addr = nx_q;
        we_prev = 1'b1;
        state_d = pts_pkg::ST_D_HEAD;
      end
      pts_pkg::ST_D_HEAD: begin
        if (!vld(delayed_head_q)) begin
          delayed_head_d = slot_q;
          we_prev        = 1'b1;
          state_d        = pts_pkg::ST_SCHED;
        end else begin
          p_d     = delayed_head_q;
          n_d     = '0;
          state_d = pts_pkg::ST_D_WALK;
        end
      end
      pts_pkg::ST_D_WALK: begin
        if (vld(rd_next) && n_q < NONE) begin
          p_d = rd_next;
          n_d = n_q + W'(1);
        end else begin
          state_d = pts_pkg::ST_D_LINK1;
        end
      end
      pts_pkg::ST_D_LINK1: begin
        wr_addr = p_q;
        we_next = 1'b1;
        wd_next = slot_q;
        state_d = pts_pkg::ST_D_LINK2;
      end
      pts_pkg::ST_D_LINK2: begin
        we_prev = 1'b1;
        wd_prev = p_q;
        state_d = pts_pkg::ST_SCHED;
      end
      pts_pkg::ST_T_WALK: begin
        if (vld(p_q) && tn_q < NONE) begin
          nx_d    = rd_next;
          wr_addr = p_q;
          we_rem  = 1'b1;
          wd_rem  = rd_rem - 16'd1;
          if (rd_rem == 16'd1) begin
            pv_d       = rd_prev;
            slot_d     = p_q;
            ins_prio_d = rd_prio;
            state_d    = pts_pkg::ST_T_UNLINK1;
          end else begin
            p_d  = rd_next;
            tn_d = tn_q + W'(1);
          end
        end else begin
          state_d = pts_pkg::ST_DONE;
        end
      end
      pts_pkg::ST_T_UNLINK1: begin
        if (vld(pv_q)) begin
          wr_addr = pv_q;
          we_next = 1'b1;
          wd_next = nx_q;
        end else begin
          delayed_head_d = nx_q;
        end
        state_d = pts_pkg::ST_T_UNLINK2;
      end
      pts_pkg::ST_T_UNLINK2: begin
        if (vld(nx_q)) begin
          wr_addr = nx_q;
          we_prev = 1'b1;
          wd_prev = pv_q;
        end
        p_d        = ready_head_q;
        last_d     = NONE;
        n_d        = '0;
        ret_tick_d = 1'b1;
        state_d    = pts_pkg::ST_INS_WALK;
      end
      pts_pkg::ST_T_CONT: begin
        p_d     = nx_q;
        tn_d    = tn_q + W'(1);
        state_d = pts_pkg::ST_T_WALK;
      end
      pts_pkg::ST_SCHED: begin
        if (started_q && vld(ready_head_q) && cur_q != ready_head_q) begin
          cur_d    = ready_head_q;
          sw_cnt_d = sw_cnt_q + 16'd1;
          sw_d     = 1'b1;
        end
        state_d = pts_pkg::ST_DONE;
      end
      pts_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != pts_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_ready_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld(ready_head_q))
    else $error("ready list lost its head");

  a_switch_has_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.switched |-> out_data_o.running_valid)
    else $error("switch reported with no running task");

  a_switch_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pts_pkg::ST_SCHED && sw_d |=> sw_cnt_q == $past(sw_cnt_q) + 16'd1)
    else $error("context switch not counted");
`endif

endmodule

// ----- tb/priority_task_scheduler_with_delays_tb.sv -----
// Testbench for the priority task scheduler: directed table, random events, predicted status.
`timescale 1ns / 1ps

module priority_task_scheduler_with_delays_tb;

  localparam int NTASKS = 8;
  localparam int NSLOT = NTASKS + 1;
  localparam logic [3:0] NO_SLOT = 4'(NSLOT);
  localparam int N_RANDOM = 1000;
  localparam int STALL_LIMIT = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  pts_pkg::in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  pts_pkg::out_item_t out_data_o;

  priority_task_scheduler_with_delays #(.MAX_TASKS(NTASKS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // scheduler image kept by the testbench
  pts_pkg::slot_status_e kstat[NSLOT];
  logic [7:0]   kprio[NSLOT];
  logic [15:0]  kleft[NSLOT];
  logic [3:0]   knext[NSLOT];
  logic [3:0]   kprev[NSLOT];
  logic [3:0]   rdy_head, dly_head, fre_head, cur_task;
  logic         is_started;
  logic [7:0]   isr_depth;
  logic [15:0]  n_switches, n_ticks;

  pts_pkg::out_item_t status_q[$];
  int        n_errors = 0;
  int        idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic bit ok(logic [3:0] s);
    return s < NSLOT;
  endfunction

  task automatic sched_reset();
    for (int i = 0; i < NSLOT; i++) begin
      kstat[i] = pts_pkg::SLOT_FREE;
      kprio[i] = '0;
      kleft[i] = '0;
      kprev[i] = NO_SLOT;
      knext[i] = (i >= 1 && i + 1 < NSLOT) ? 4'(i + 1) : NO_SLOT;
    end
    kstat[0] = pts_pkg::SLOT_READY;
    kprio[0] = pts_pkg::IDLE_PRIORITY;
    rdy_head = 4'd0;
    dly_head = NO_SLOT;
    fre_head = 4'd1;
    cur_task = NO_SLOT;
    is_started = 1'b0;
    isr_depth = '0;
    n_switches = '0;
    n_ticks = '0;
  endtask

  task automatic ready_link(input logic [3:0] s);
    logic [3:0] p;
    logic [3:0] last;
    int n;
    p = rdy_head;
    last = NO_SLOT;
    n = 0;
    while (ok(p) && n < NSLOT) begin
      if (kprio[s] < kprio[p]) break;
      last = p;
      p = knext[p];
      n++;
    end
    if (!ok(p)) p = NO_SLOT;
    kprev[s] = last;
    knext[s] = p;
    if (ok(last)) knext[last] = s;
    else rdy_head = s;
    if (ok(p)) kprev[p] = s;
    kstat[s] = pts_pkg::SLOT_READY;
  endtask

  function automatic bit dispatch();
    if (!is_started || !ok(rdy_head) || cur_task == rdy_head) return 1'b0;
    cur_task = rdy_head;
    n_switches++;
    return 1'b1;
  endfunction

  task automatic apply_event(input pts_pkg::in_item_t ev, output pts_pkg::out_item_t st);
    logic [3:0] s, nx, t, p, pv;
    bit sw, err;
    logic [3:0] made;
    int n;
    sw = 0; err = 0; made = '0;
    case (ev.mode)
      pts_pkg::MODE_CREATE: begin
        s = fre_head;
        if (!ok(s)) err = 1;
        else begin
          fre_head = knext[s];
          if (ok(fre_head)) kprev[fre_head] = NO_SLOT;
          kprio[s] = ev.priority_req;
          kleft[s] = '0;
          ready_link(s);
          made = s;
          sw = dispatch();
        end
      end
      pts_pkg::MODE_DELAY: begin
        if (ev.delay_ticks != 0 && ok(rdy_head)) begin
          s = rdy_head;
          nx = knext[s];
          if (!ok(nx)) err = 1;
          else begin
            t = dly_head;
            n = 0;
            rdy_head = nx;
            kprev[nx] = NO_SLOT;
            kleft[s] = ev.delay_ticks;
            kstat[s] = pts_pkg::SLOT_DELAYED;
            knext[s] = NO_SLOT;
            if (!ok(t)) begin
              dly_head = s;
              kprev[s] = NO_SLOT;
            end else begin
              while (ok(knext[t]) && n < NSLOT) begin
                t = knext[t];
                n++;
              end
              knext[t] = s;
              kprev[s] = t;
            end
            sw = dispatch();
          end
        end
      end
      pts_pkg::MODE_TICK: begin
        p = dly_head;
        n = 0;
        n_ticks++;
        while (ok(p) && n < NSLOT) begin
          nx = knext[p];
          kleft[p] = kleft[p] - 16'd1;
          if (kleft[p] == 0) begin
            pv = kprev[p];
            if (ok(pv)) knext[pv] = nx;
            else dly_head = ok(nx) ? nx : NO_SLOT;
            if (ok(nx)) kprev[nx] = pv;
            ready_link(p);
          end
          p = nx;
          n++;
        end
      end
      pts_pkg::MODE_START: begin
        is_started = 1'b1;
        sw = dispatch();
      end
      pts_pkg::MODE_ISR_ENTER: if (isr_depth != pts_pkg::ISR_DEPTH_MAX) isr_depth++;
      pts_pkg::MODE_ISR_EXIT: begin
        if (isr_depth != 0) begin
          isr_depth--;
          if (isr_depth == 0) sw = dispatch();
        end
      end
      default: ;
    endcase
    st.running_valid = ok(cur_task);
    st.running_task  = ok(cur_task) ? cur_task : 4'd0;
    st.switched      = sw;
    st.new_task      = made;
    st.error         = err;
    st.switch_count  = n_switches;
    st.tick_count    = n_ticks;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, checks each beat against the oldest prediction
  int stall_left;
  bit quiet_out;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("pending predictions", 0, 1);
        end else begin
          pts_pkg::out_item_t w;
          w = status_q.pop_front();
          if (out_data_o.running_valid !== w.running_valid)
            report_mismatch("running_valid", out_data_o.running_valid, w.running_valid);
          if (out_data_o.running_task !== w.running_task)
            report_mismatch("running_task", out_data_o.running_task, w.running_task);
          if (out_data_o.switched !== w.switched)
            report_mismatch("switched", out_data_o.switched, w.switched);
          if (out_data_o.new_task !== w.new_task)
            report_mismatch("new_task", out_data_o.new_task, w.new_task);
          if (out_data_o.error !== w.error)
            report_mismatch("error", out_data_o.error, w.error);
          if (out_data_o.switch_count !== w.switch_count)
            report_mismatch("switch_count", out_data_o.switch_count, w.switch_count);
          if (out_data_o.tick_count !== w.tick_count)
            report_mismatch("tick_count", out_data_o.tick_count, w.tick_count);
        end
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
        stall_left  <= gap_len();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  typedef struct {
    pts_pkg::in_item_t  ev;
    bit                 typed;
    pts_pkg::out_item_t want;
  } row_t;

  row_t rows[$];

  function automatic pts_pkg::in_item_t mk(pts_pkg::mode_e m, int pr, int dl);
    pts_pkg::in_item_t e;
    e.mode = m;
    e.priority_req = 8'(pr);
    e.delay_ticks = 16'(dl);
    return e;
  endfunction

  function automatic pts_pkg::out_item_t st(bit rv, int rt, bit sw, int nt, bit er, int sc,
                                            int tc);
    pts_pkg::out_item_t o;
    o.running_valid = rv; o.running_task = 4'(rt); o.switched = sw;
    o.new_task = 4'(nt); o.error = er; o.switch_count = 16'(sc); o.tick_count = 16'(tc);
    return o;
  endfunction

  task automatic add(pts_pkg::in_item_t e);
    rows.push_back('{e, 1'b0, '0});
  endtask

  task automatic add_typed(pts_pkg::in_item_t e, pts_pkg::out_item_t w);
    rows.push_back('{e, 1'b1, w});
  endtask

  // one beat; prediction made at acceptance, valid kept high into the next beat unless a gap comes first
  task automatic send(input pts_pkg::in_item_t e, input bit typed,
                      input pts_pkg::out_item_t want);
    pts_pkg::out_item_t p;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= e;
    do @(posedge clk_i); while (in_stall_o);
    apply_event(e, p);
    if (typed && p !== want) report_mismatch("directed row agrees", 0, 1);
    status_q.push_back(p);
  endtask

  function automatic pts_pkg::in_item_t rand_event();
    pts_pkg::in_item_t e;
    int r;
    r = $urandom_range(0, 99);
    e.priority_req = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(95, 105));
    e.delay_ticks = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (r < 20) e.mode = pts_pkg::MODE_CREATE;
    else if (r < 42) e.mode = pts_pkg::MODE_DELAY;
    else if (r < 75) e.mode = pts_pkg::MODE_TICK;
    else if (r < 80) e.mode = pts_pkg::MODE_START;
    else if (r < 89) e.mode = pts_pkg::MODE_ISR_ENTER;
    else if (r < 98) e.mode = pts_pkg::MODE_ISR_EXIT;
    else e.mode = pts_pkg::mode_e'(3'($urandom_range(6, 7)));
    return e;
  endfunction

  initial begin
    pts_pkg::in_item_t e;
    quiet_out = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    sched_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: no running task before the start event
    add_typed(mk(pts_pkg::MODE_TICK, 0, 0), st(0, 0, 0, 0, 0, 0, 1));
    add_typed(mk(pts_pkg::MODE_DELAY, 0, 5), st(0, 0, 0, 0, 1, 0, 1));
    add_typed(mk(pts_pkg::MODE_CREATE, 255, 0), st(0, 0, 0, 1, 0, 0, 1));
    add_typed(mk(pts_pkg::MODE_START, 0, 0), st(1, 0, 1, 0, 0, 1, 1));
    add_typed(mk(pts_pkg::MODE_CREATE, 0, 0), st(1, 2, 1, 2, 0, 2, 1));
    add(mk(pts_pkg::MODE_CREATE, 100, 0));
    add(mk(pts_pkg::MODE_CREATE, 0, 0));
    add(mk(pts_pkg::MODE_DELAY, 0, 0));
    add(mk(pts_pkg::MODE_DELAY, 0, 16'hFFFF));
    add(mk(pts_pkg::MODE_DELAY, 0, 1));
    add(mk(pts_pkg::MODE_TICK, 0, 0));
    add(mk(pts_pkg::MODE_ISR_ENTER, 0, 0));
    add(mk(pts_pkg::MODE_CREATE, 1, 0));
    add(mk(pts_pkg::MODE_ISR_EXIT, 0, 0));
    add(mk(pts_pkg::MODE_ISR_EXIT, 0, 0));
    add(mk(pts_pkg::MODE_CREATE, 200, 0));
    add(mk(pts_pkg::MODE_CREATE, 50, 0));
    add(mk(pts_pkg::MODE_CREATE, 50, 0));
    add(mk(pts_pkg::MODE_CREATE, 7, 0));
    add(mk(pts_pkg::MODE_CREATE, 9, 0));
    add(mk(pts_pkg::MODE_START, 0, 0));
    add(mk(pts_pkg::mode_e'(3'd6), 8'hAA, 16'h5555));
    add(mk(pts_pkg::mode_e'(3'd7), 8'h55, 16'hAAAA));
    foreach (rows[i]) send(rows[i].ev, rows[i].typed, rows[i].want);

    // ISR depth saturation
    repeat (258) send(mk(pts_pkg::MODE_ISR_ENTER, 0, 0), 1'b0, '0);
    repeat (258) send(mk(pts_pkg::MODE_ISR_EXIT, 0, 0), 1'b0, '0);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2) begin
        // hold off until the output side has drained, with the receiver eager
        in_valid_i <= 1'b0;
        quiet_out = 1'b1;
        while (status_q.size() != 0) @(posedge clk_i);
        quiet_out = 1'b0;
      end
      // keep ISR nesting shallow so scheduling passes stay frequent
      e = rand_event();
      if (e.mode == pts_pkg::MODE_ISR_ENTER && isr_depth > 3) e.mode = pts_pkg::MODE_ISR_EXIT;
      send(e, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- priority_task_scheduler_with_delays.f -----
hdl/pts_pkg.sv
hdl/priority_task_scheduler_with_delays.sv
tb/priority_task_scheduler_with_delays_tb.sv
